// ----- hw/rtl/pett_pkg.sv -----
// Shared types, codes and sizes for the periodic event timer table.
`timescale 1ns / 1ps

package pett_pkg;

    localparam int NumEntries = 16;
    localparam int TagBits    = 16;
    localparam int TsW        = 32;
    localparam int GranW      = 16;
    localparam int IdxW       = (NumEntries > 1) ? $clog2(NumEntries) : 1;
    localparam int CntW       = $clog2(NumEntries + 1);

    typedef enum logic [1:0] {
        FUNC_REG   = 2'd0,
        FUNC_UNREG = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_DUP      = 2'd1,
        STAT_ZERO_IVL = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SHIFT,
        ST_TICK,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [TagBits-1:0] tag;
        logic [TsW-1:0]     interval;
        logic [TsW-1:0]     last_trig;
    } t_entry;

endpackage

// ----- hw/rtl/pett_if.sv -----
// Handshake channels of the periodic event timer table: request, result, configuration.
`timescale 1ns / 1ps

interface pett_req_if;
    import pett_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [TagBits-1:0] tag;
    logic [TsW-1:0]     interval;
    modport source (output valid, func, tag, interval, input ready);
    modport sink   (input valid, func, tag, interval, output ready);
endinterface

interface pett_rsp_if;
    import pett_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               fired;
    logic [TagBits-1:0] fired_tag;
    logic               last;
    modport source (output valid, status, fired, fired_tag, last, input ready);
    modport sink   (input valid, status, fired, fired_tag, last, output ready);
endinterface

interface pett_cfg_if;
    import pett_pkg::*;
    logic             valid;
    logic             ready;
    logic [GranW-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/pett_due_unit.sv -----
// Shared elapsed-time unit: wrapping subtract and compare against the interval.
`timescale 1ns / 1ps

module pett_due_unit (
    input  logic [pett_pkg::TsW-1:0] i_now,
    input  logic [pett_pkg::TsW-1:0] i_last,
    input  logic [pett_pkg::TsW-1:0] i_interval,
    output logic                     o_due
);
    import pett_pkg::*;

    logic [TsW-1:0] elapsed;

    // The subtraction wraps modulo 2^32, as the timestamp does.
    assign elapsed = i_now - i_last;
    assign o_due   = (elapsed >= i_interval);

endmodule

// ----- hw/rtl/periodic_event_timer_table_unit.sv -----
// Top level of the periodic event timer table: entry store, sequencer and result register.
`timescale 1ns / 1ps

// The block keeps up to 16 periodic events in registration order and handles one
// request at a time; i_req.ready is low while a request is in progress. A register
// or unregister request walks the table one entry per cycle looking for the tag; an
// unregister that hits then moves each later entry down by one, one entry per cycle.
// A zero-interval register and a clear go straight to their result. A tick advances
// the timestamp and then passes each entry through the single elapsed-time compare
// unit, one entry per cycle while no fired result waits on a full result register.
// Results go out through one output register; the last result of a request carries
// last = 1, and a new request can be taken while that final result still waits. Any
// request whose own result finds that register still full waits until the earlier
// result is taken. Granularity is written through i_cfg, which is always ready, and
// should only be written while the block is idle. Entries above the current count
// hold stale data and are never read.

module periodic_event_timer_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pett_cfg_if.sink    i_cfg,
    pett_req_if.sink    i_req,
    pett_rsp_if.source  o_rsp
);
    import pett_pkg::*;

    t_state             r_state, n_state;
    t_func              r_func;
    logic [TagBits-1:0] r_tag;
    logic [TsW-1:0]     r_ivl;
    logic [CntW-1:0]    r_idx, n_idx;
    logic [CntW-1:0]    r_count, n_count;
    logic [TsW-1:0]     r_ts, n_ts;
    logic [GranW-1:0]   r_gran;
    t_status            r_st, n_st;
    logic               r_pend, n_pend;
    logic [TagBits-1:0] r_pend_tag, n_pend_tag;

    // Result register.
    logic               r_ov, n_ov;
    t_status            r_ostat, n_ostat;
    logic               r_ofired, n_ofired;
    logic [TagBits-1:0] r_otag, n_otag;
    logic               r_olast, n_olast;

    // Entry store: one read address and one write address per cycle.
    t_entry             r_mem [NumEntries];
    t_entry             rd_entry;
    t_entry             wr_data;
    logic               wr_en;
    logic [IdxW-1:0]    wr_addr;
    logic [IdxW-1:0]    rd_addr;

    logic               req_acc;
    logic               slot_free;
    logic               at_end;
    logic               tag_hit;
    logic               due;
    logic [CntW-1:0]    idx_inc;

    assign req_acc   = i_req.valid && i_req.ready;
    assign slot_free = !r_ov || o_rsp.ready;
    assign at_end    = (r_idx == r_count);
    assign idx_inc   = r_idx + CntW'(1);
    assign rd_addr   = (r_state == ST_SHIFT) ? idx_inc[IdxW-1:0] : r_idx[IdxW-1:0];
    assign rd_entry  = r_mem[rd_addr];
    assign tag_hit   = (rd_entry.tag == r_tag);

    // The one compare unit that every tick walks through.
    pett_due_unit u_due (
        .i_now      (r_ts),
        .i_last     (rd_entry.last_trig),
        .i_interval (rd_entry.interval),
        .o_due      (due)
    );

    assign i_req.ready     = (r_state == ST_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_rsp.valid     = r_ov;
    assign o_rsp.status    = r_ostat;
    assign o_rsp.fired     = r_ofired;
    assign o_rsp.fired_tag = r_otag;
    assign o_rsp.last      = r_olast;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    unique case (t_func'(i_req.func))
                        FUNC_REG:   n_state = (i_req.interval == '0) ? ST_RESP : ST_FIND;
                        FUNC_UNREG: n_state = ST_FIND;
                        FUNC_TICK:  n_state = ST_TICK;
                        FUNC_CLEAR: n_state = ST_RESP;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FIND: begin
                if (at_end) begin
                    n_state = ST_RESP;
                end else if (tag_hit) begin
                    n_state = (r_func == FUNC_REG) ? ST_RESP : ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (idx_inc >= r_count) begin
                    n_state = ST_RESP;
                end
            end
            ST_TICK: begin
                if (at_end && slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RESP: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, store writes and result register loads for each state.
    always_comb begin
        n_idx      = r_idx;
        n_count    = r_count;
        n_ts       = r_ts;
        n_st       = r_st;
        n_pend     = r_pend;
        n_pend_tag = r_pend_tag;
        n_ov       = r_ov && !o_rsp.ready;
        n_ostat    = r_ostat;
        n_ofired   = r_ofired;
        n_otag     = r_otag;
        n_olast    = r_olast;
        wr_en      = 1'b0;
        wr_addr    = r_idx[IdxW-1:0];
        wr_data    = rd_entry;

        unique case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_st   = STAT_OK;
                    unique case (t_func'(i_req.func))
                        FUNC_REG: begin
                            if (i_req.interval == '0) begin
                                n_st = STAT_ZERO_IVL;
                            end
                        end
                        FUNC_UNREG: n_st = STAT_OK;
                        FUNC_TICK:  n_ts = r_ts + TsW'(r_gran);
                        FUNC_CLEAR: n_count = '0;
                        default:    n_st = STAT_OK;
                    endcase
                end
            end
            ST_FIND: begin
                if (at_end) begin
                    if (r_func == FUNC_REG) begin
                        if (r_count >= CntW'(NumEntries)) begin
                            n_st = STAT_FULL;
                        end else begin
                            wr_en             = 1'b1;
                            wr_addr           = r_count[IdxW-1:0];
                            wr_data.tag       = r_tag;
                            wr_data.interval  = r_ivl;
                            wr_data.last_trig = '0;
                            n_count           = r_count + CntW'(1);
                            n_st              = STAT_OK;
                        end
                    end
                end else if (tag_hit) begin
                    // Register of a known tag is refused; unregister starts the
                    // shift at the matching entry.
                    if (r_func == FUNC_REG) begin
                        n_st = STAT_DUP;
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end
            ST_SHIFT: begin
                if (idx_inc < r_count) begin
                    wr_en = 1'b1;
                    n_idx = idx_inc;
                end else begin
                    n_count = r_count - CntW'(1);
                    n_st    = STAT_OK;
                end
            end
            ST_TICK: begin
                // A fired tag is held back until the next one is found, so that the
                // final fired result can be marked last.
                if (!at_end) begin
                    if (!due) begin
                        n_idx = idx_inc;
                    end else if (!r_pend || slot_free) begin
                        wr_en             = 1'b1;
                        wr_data.last_trig = r_ts;
                        n_idx             = idx_inc;
                        n_pend            = 1'b1;
                        n_pend_tag        = rd_entry.tag;
                        if (r_pend) begin
                            n_ov     = 1'b1;
                            n_ostat  = STAT_OK;
                            n_ofired = 1'b1;
                            n_otag   = r_pend_tag;
                            n_olast  = 1'b0;
                        end
                    end
                end else if (slot_free) begin
                    n_ov     = 1'b1;
                    n_ostat  = STAT_OK;
                    n_ofired = r_pend;
                    n_otag   = r_pend ? r_pend_tag : '0;
                    n_olast  = 1'b1;
                    n_pend   = 1'b0;
                end
            end
            ST_RESP: begin
                if (slot_free) begin
                    n_ov     = 1'b1;
                    n_ostat  = r_st;
                    n_ofired = 1'b0;
                    n_otag   = '0;
                    n_olast  = 1'b1;
                end
            end
            default: n_ov = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_count <= '0;
            r_ts    <= '0;
            r_gran  <= GranW'(1);
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
            r_ts    <= n_ts;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
            if (i_cfg.valid && i_cfg.ready) begin
                r_gran <= i_cfg.data;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_func <= t_func'(i_req.func);
            r_tag  <= i_req.tag;
            r_ivl  <= i_req.interval;
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_st       <= n_st;
        r_pend_tag <= n_pend_tag;
        r_ostat    <= n_ostat;
        r_ofired   <= n_ofired;
        r_otag     <= n_otag;
        r_olast    <= n_olast;
    end

endmodule

// ----- hw/rtl/pett_checker.sv -----
// Port-level checks of the periodic event timer table and their binding to the top level.
`timescale 1ns / 1ps

module pett_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         o_rsp_valid,
    input logic                         o_rsp_ready,
    input logic [1:0]                   o_rsp_status,
    input logic                         o_rsp_fired,
    input logic [pett_pkg::TagBits-1:0] o_rsp_fired_tag,
    input logic                         o_rsp_last
);
    import pett_pkg::*;

    // A result that is not taken stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_ready |=> o_rsp_valid)
        else $error("result withdrawn before it was taken");

    // The block is busy in the cycle after it takes a request.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while the previous one is still in progress");

    // No new request while a request still owes results.
    a_no_req_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_last |-> !i_req_ready)
        else $error("ready while a fired burst is incomplete");

    // A result without a fired event is the only result of its request.
    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !o_rsp_fired |-> o_rsp_last && (o_rsp_fired_tag == '0))
        else $error("non-fired result is not a single final result");

    // Fired results always report success.
    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_fired |-> (o_rsp_status == STAT_OK))
        else $error("fired result with error status");

endmodule

bind periodic_event_timer_table_unit pett_checker u_pett_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .o_rsp_valid     (o_rsp.valid),
    .o_rsp_ready     (o_rsp.ready),
    .o_rsp_status    (o_rsp.status),
    .o_rsp_fired     (o_rsp.fired),
    .o_rsp_fired_tag (o_rsp.fired_tag),
    .o_rsp_last      (o_rsp.last)
);

// ----- bench/tb_top.sv -----
// Self-checking testbench for the periodic event timer table unit.
`timescale 1ns / 1ps

// The bench drives requests into the timer table, keeps its own copy of the table,
// the timestamp and the granularity, and works out the results that each accepted
// request must produce. A checker process compares every accepted result, field by
// field, with the oldest expected one. Directed tests come first: the register rules
// and their order of precedence, tick order, a full table, unregister with shifting,
// clear, and the granularity extremes. A run of large ticks back to back follows, a
// long result stall fills the block up, and random traffic runs under several
// granularities. The last random phase runs without idling.
module tb_top;
    import pett_pkg::*;

    localparam int ClkHalf      = 4;
    localparam int CycleLimit   = 2_000_000;
    localparam int SettleCycles = 32;       // longer than a walk over a full table
    localparam int MissShown    = 10;
    localparam int LongTicks    = 40;       // ticks in the back-to-back large-step run

    typedef struct packed {
        t_status            status;
        logic               fired;
        logic [TagBits-1:0] tag;
        logic               last;
    } t_timer_report;

    logic clk;
    logic rst_n;

    pett_cfg_if cfg_ch ();
    pett_req_if req_ch ();
    pett_rsp_if rsp_ch ();

    periodic_event_timer_table_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Expected state of the table, updated when a request is accepted.
    logic [TsW-1:0]     now_ts;
    int                 n_entries;
    logic [TagBits-1:0] tbl_tag      [NumEntries];
    logic [TsW-1:0]     tbl_period   [NumEntries];
    logic [TsW-1:0]     tbl_fired_at [NumEntries];
    logic [GranW-1:0]   step_size;

    t_timer_report expected_reports[$];
    t_timer_report want;

    int miss_count      = 0;
    int cycle_count     = 0;
    int rsp_hold_cycles = 0;
    bit calm            = 1'b0;    // no idling on either side while set

    initial clk = 1'b0;
    always #ClkHalf clk = ~clk;

    // The run ends here if the block stops making progress.
    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void note_miss(string msg);
        miss_count = miss_count + 1;
        if (miss_count <= MissShown) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    function automatic int find_tag(logic [TagBits-1:0] tag);
        int i;
        for (i = 0; i < n_entries; i++) begin
            if (tbl_tag[i] == tag) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void push_report(t_status status, logic fired,
                                        logic [TagBits-1:0] tag, logic last);
        t_timer_report r;
        r.status = status;
        r.fired  = fired;
        r.tag    = tag;
        r.last   = last;
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    // Applies one accepted request to the table copy and queues its results.
    function automatic void advance_timer_table(t_func func, logic [TagBits-1:0] tag,
                                                logic [TsW-1:0] period);
        int             i;
        int             pos;
        int             n_hit;
        int             k;
        logic [TsW-1:0] elapsed;
        bit             hit [NumEntries];
        case (func)
            FUNC_REG: begin
                // A zero interval wins over a duplicate, which wins over a full table.
                if (period == '0) begin
                    push_report(STAT_ZERO_IVL, 1'b0, '0, 1'b1);
                end else if (find_tag(tag) >= 0) begin
                    push_report(STAT_DUP, 1'b0, '0, 1'b1);
                end else if (n_entries >= NumEntries) begin
                    push_report(STAT_FULL, 1'b0, '0, 1'b1);
                end else begin
                    tbl_tag[n_entries]      = tag;
                    tbl_period[n_entries]   = period;
                    tbl_fired_at[n_entries] = '0;
                    n_entries               = n_entries + 1;
                    push_report(STAT_OK, 1'b0, '0, 1'b1);
                end
            end
            FUNC_UNREG: begin
                // Later entries move down so registration order is kept.
                pos = find_tag(tag);
                if (pos >= 0) begin
                    for (i = pos; i < n_entries - 1; i++) begin
                        tbl_tag[i]      = tbl_tag[i + 1];
                        tbl_period[i]   = tbl_period[i + 1];
                        tbl_fired_at[i] = tbl_fired_at[i + 1];
                    end
                    n_entries = n_entries - 1;
                end
                push_report(STAT_OK, 1'b0, '0, 1'b1);
            end
            FUNC_CLEAR: begin
                n_entries = 0;
                push_report(STAT_OK, 1'b0, '0, 1'b1);
            end
            default: begin
                now_ts = now_ts + TsW'(step_size);
                n_hit  = 0;
                for (i = 0; i < n_entries; i++) begin
                    elapsed = now_ts - tbl_fired_at[i];
                    hit[i]  = (elapsed >= tbl_period[i]);
                    if (hit[i]) begin
                        tbl_fired_at[i] = now_ts;
                        n_hit           = n_hit + 1;
                    end
                end
                if (n_hit == 0) begin
                    push_report(STAT_OK, 1'b0, '0, 1'b1);
                end else begin
                    k = 0;
                    for (i = 0; i < n_entries; i++) begin
                        if (hit[i]) begin
                            k = k + 1;
                            push_report(STAT_OK, 1'b1, tbl_tag[i], (k == n_hit));
                        end
                    end
                end
            end
        endcase
    endfunction

    // Result side: random stall bursts, or one long hold-off when a test asks for it.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (rsp_hold_cycles) @(negedge clk);
                rsp_hold_cycles = 0;
                rsp_ch.ready    = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                rsp_ch.ready = 1'b1;
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_reports.size() == 0) begin
                note_miss($sformatf("result with none expected: status %0d fired %0b tag %h last %0b",
                                    rsp_ch.status, rsp_ch.fired, rsp_ch.fired_tag, rsp_ch.last));
            end else begin
                want = expected_reports.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.fired !== want.fired ||
                    rsp_ch.fired_tag !== want.tag || rsp_ch.last !== want.last) begin
                    note_miss($sformatf({"mismatch: expected status %0d fired %0b tag %h last %0b,",
                                         " got status %0d fired %0b tag %h last %0b"},
                                        want.status, want.fired, want.tag, want.last,
                                        rsp_ch.status, rsp_ch.fired, rsp_ch.fired_tag,
                                        rsp_ch.last));
                end
            end
        end
    end

    // Offers one request and returns at the edge that accepts it. Valid stays high so a
    // following request goes out without a gap; a pause lowers it first.
    task automatic send_request(t_func func, logic [TagBits-1:0] tag, logic [TsW-1:0] period);
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        req_ch.func     = func;
        req_ch.tag      = tag;
        req_ch.interval = period;
        req_ch.valid    = 1'b1;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        advance_timer_table(func, tag, period);
    endtask

    // Stops offering requests and waits until every expected result has arrived.
    task automatic wait_for_idle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_granularity(logic [GranW-1:0] value);
        wait_for_idle();
        @(negedge clk);
        cfg_ch.data  = value;
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        step_size = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Zero interval, tag extremes, duplicate, and zero interval over a duplicate.
    task automatic test_register_rules();
        send_request(FUNC_REG, 16'h1234, '0);
        send_request(FUNC_REG, 16'h0000, 32'd1);
        send_request(FUNC_REG, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(FUNC_REG, 16'h0000, 32'd5);
        send_request(FUNC_REG, 16'h0000, '0);
    endtask

    // Single fire, then several fires that must come out in table order.
    task automatic test_tick_order();
        send_request(FUNC_TICK, 16'h0000, '0);
        send_request(FUNC_REG, 16'h00A5, 32'd2);
        send_request(FUNC_REG, 16'h5A00, 32'd1);
        send_request(FUNC_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // Fills the table, then checks the full status and its precedence, and a tick over
    // all sixteen entries.
    task automatic test_full_table();
        int i;
        i = 0;
        while (n_entries < NumEntries) begin
            send_request(FUNC_REG, 16'h0100 + i[15:0], 32'd1 + (i % 4));
            i = i + 1;
        end
        send_request(FUNC_REG, 16'h0200, 32'd3);
        send_request(FUNC_REG, tbl_tag[3], 32'd3);
        send_request(FUNC_REG, 16'h0201, '0);
        send_request(FUNC_TICK, '0, '0);
    endtask

    // Absent tag, then removal from the middle, the front and the back.
    task automatic test_unregister();
        send_request(FUNC_UNREG, 16'h7777, '0);
        send_request(FUNC_UNREG, tbl_tag[5], '0);
        send_request(FUNC_UNREG, tbl_tag[0], '0);
        send_request(FUNC_UNREG, tbl_tag[n_entries - 1], '0);
        send_request(FUNC_TICK, '0, '0);
    endtask

    // Clear empties the table but the timestamp runs on.
    task automatic test_clear();
        send_request(FUNC_CLEAR, '0, '0);
        send_request(FUNC_TICK, '0, '0);
        send_request(FUNC_UNREG, 16'h8001, '0);
        send_request(FUNC_REG, 16'h8001, 32'd1);
        send_request(FUNC_TICK, '0, '0);
    endtask

    // A granularity of zero freezes time; the largest one jumps ahead.
    task automatic test_granularity_extremes();
        write_granularity('0);
        send_request(FUNC_TICK, '0, '0);
        send_request(FUNC_TICK, '0, '0);
        write_granularity(16'hFFFF);
        send_request(FUNC_TICK, '0, '0);
    endtask

    // Back-to-back ticks of the largest step over an entry that fires every third
    // tick and one whose interval is half the timestamp range.
    task automatic test_long_tick_run();
        int j;
        write_granularity(16'hFFFF);
        send_request(FUNC_CLEAR, '0, '0);
        send_request(FUNC_REG, 16'hC3C3, 32'd196605);
        send_request(FUNC_REG, 16'h3C3C, 32'h8000_0000);
        calm = 1'b1;
        for (j = 0; j < LongTicks; j++) begin
            send_request(FUNC_TICK, '0, '0);
        end
        wait_for_idle();
        calm = 1'b0;
    endtask

    // The result side holds off for a long stretch while requests keep coming, so the
    // block fills up and stops taking requests; then the sender waits for every result.
    task automatic test_result_backpressure();
        int j;
        write_granularity(16'd1);
        calm            = 1'b1;
        rsp_hold_cycles = 300;
        for (j = 0; j < 12; j++) begin
            if (j % 2 == 0) begin
                send_request(FUNC_REG, 16'h9000 + j[15:0], 32'd1);
            end else begin
                send_request(FUNC_TICK, '0, '0);
            end
        end
        wait_for_idle();
        calm = 1'b0;
    endtask

    // Mostly well-formed traffic: registers with intervals close to the tick step so
    // entries fire often, unregisters of present tags, ticks, and a little noise.
    task automatic test_random_traffic(int n_items, logic [GranW-1:0] gran);
        int                 j;
        int                 roll;
        int                 pick;
        int                 step;
        logic [TagBits-1:0] tag;
        logic [TsW-1:0]     period;
        write_granularity(gran);
        step = (gran == '0) ? 1 : int'(gran);
        for (j = 0; j < n_items; j++) begin
            roll = $urandom_range(0, 99);
            tag  = TagBits'($urandom_range(0, 65535));
            if (roll < 40) begin
                if (n_entries > 0 && $urandom_range(0, 6) == 0) begin
                    tag = tbl_tag[$urandom_range(0, n_entries - 1)];
                end
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    period = '0;
                end else if (pick < 3) begin
                    period = $urandom();
                end else begin
                    period = $urandom_range(1, 6 * step);
                end
                send_request(FUNC_REG, tag, period);
            end else if (roll < 55) begin
                if (n_entries > 0 && $urandom_range(0, 3) != 0) begin
                    tag = tbl_tag[$urandom_range(0, n_entries - 1)];
                end
                send_request(FUNC_UNREG, tag, $urandom());
            end else if (roll < 58) begin
                send_request(FUNC_CLEAR, tag, $urandom());
            end else begin
                send_request(FUNC_TICK, tag, $urandom());
            end
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.func     = FUNC_REG;
        req_ch.tag      = '0;
        req_ch.interval = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        now_ts          = '0;
        n_entries       = 0;
        step_size       = 16'd1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_rules();
        test_tick_order();
        test_full_table();
        test_unregister();
        test_clear();
        test_granularity_extremes();
        test_long_tick_run();
        test_result_backpressure();
        test_random_traffic(60, 16'd1);
        test_random_traffic(50, GranW'($urandom_range(2, 1000)));
        test_random_traffic(20, '0);
        test_random_traffic(40, 16'hFFFF);
        // The closing phase runs with no idling on either side.
        wait_for_idle();
        calm = 1'b1;
        test_random_traffic(40, GranW'($urandom_range(1, 65535)));
        wait_for_idle();

        if (miss_count == 0 && expected_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
